@@ sv/shm_pkg.sv @@
// Shared types and constants for the sales histogram / mode / mean block.
// No dependencies; imported by every module of the block.
package shm_pkg;

    localparam int S_DATA_W   = 48;   // product_id, paid_cents, change_cents
    localparam int S_USER_W   = 1;    // action
    localparam int M_DATA_W   = 104;  // five report fields, already whole bytes

    localparam int COUNT_W    = 16;
    localparam int REV_W      = 32;
    localparam int MODE_W     = 8;
    localparam int DIV_STEP_W = 5;    // counts 32 quotient bits

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [MODE_W-1:0]  NO_MODE   = '1;   // -1
    localparam logic [REV_W-1:0]   REV_MAX   = 32'h7FFF_FFFF;
    localparam logic [REV_W-1:0]   REV_MIN   = 32'h8000_0000;

    // action codes on s_tuser
    localparam logic ACT_SALE   = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [REV_W-1:0]   rev_t;

    typedef struct packed {
        count_t             top_count;
        logic [MODE_W-1:0]  top_product;
        rev_t               mean_cents;
        rev_t               revenue_cents;
        count_t             total_sales;
    } report_t;

endpackage

@@ sv/shm_bin_mem.sv @@
// Histogram bin store: single write port, single registered read port.
// Uses shm_pkg for the bin count type.
module shm_bin_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output shm_pkg::count_t      rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  shm_pkg::count_t      wr_data
);
    import shm_pkg::*;

    count_t mem [DEPTH];
    count_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/shm_divider.sv @@
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Uses shm_pkg for widths and the rev_t and count_t types.
module shm_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  shm_pkg::rev_t     dividend,
    input  shm_pkg::count_t   divisor,
    output logic              done,
    output shm_pkg::rev_t     quotient
);
    import shm_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic                  neg_reg, neg_next;
    rev_t                  quo_reg, quo_next;
    count_t                rem_reg, rem_next;
    count_t                dvs_reg, dvs_next;
    logic [COUNT_W:0]      rem_sh;
    logic                  q_bit;
    rev_t                  magnitude;

    always_comb begin
        magnitude = dividend[REV_W-1] ? (~dividend + 1'b1) : dividend;
        rem_sh    = {rem_reg, quo_reg[REV_W-1]};
        q_bit     = rem_sh >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[REV_W-1];
            quo_next  = magnitude;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = q_bit ? COUNT_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[COUNT_W-1:0];
            quo_next = {quo_reg[REV_W-2:0], q_bit};
            step_next = step_reg + 1'b1;
            if (step_reg == '1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

@@ sv/sales_histogram_mode_mean.sv @@
// Sales histogram with running mode and mean. A sale request (s_tuser = 0)
// is done in the cycle it is accepted when its product id is outside
// 0..NUM_PRODUCTS-1; otherwise it also takes the S_UPD state for the
// read-modify-write of the bin memory. A report request (s_tuser = 1) runs
// the 32-step divider for the mean, waits for the output register to be
// free, then sweeps the bin memory back to zero one entry a cycle; the same
// sweep runs after reset. s_tready is low throughout. A finished report waits
// in the output register while the next request is accepted.
// Depends on shm_pkg, shm_bin_mem and shm_divider.
module sales_histogram_mode_mean #(
    parameter int NUM_PRODUCTS = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // product_id[15:0], paid_cents[31:16], change_cents[47:32]
    input  logic [shm_pkg::S_DATA_W-1:0]  s_tdata,
    // action[0]
    input  logic [shm_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // total_sales[15:0], revenue_cents[47:16], mean_cents[79:48],
    // top_product[87:80], top_count[103:88]
    output logic [shm_pkg::M_DATA_W-1:0]  m_tdata
);
    import shm_pkg::*;

    localparam int IDX_W = (NUM_PRODUCTS > 1) ? $clog2(NUM_PRODUCTS) : 1;
    localparam logic [15:0]      NUM_P16  = 16'(NUM_PRODUCTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PRODUCTS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [15:0]       pid_reg, pid_next;
    count_t            sales_reg, sales_next;
    rev_t              rev_reg, rev_next;
    logic [MODE_W-1:0] mode_id_reg, mode_id_next;
    count_t            mode_cnt_reg, mode_cnt_next;
    logic              m_valid_reg, m_valid_next;
    report_t           out_reg, out_next;

    logic [15:0]       s_pid, s_paid, s_change;
    logic              s_accept, in_range;
    logic [16:0]       diff;
    logic [REV_W:0]    sum33;
    rev_t              rev_sat;
    count_t            bin_rd, bin_inc;
    logic              mem_rd_en, mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    count_t            mem_wr_data;
    logic              div_start;
    logic              div_done;
    rev_t              div_q;

    assign s_pid    = s_tdata[15:0];
    assign s_paid   = s_tdata[31:16];
    assign s_change = s_tdata[47:32];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_range = !s_pid[15] && (s_pid < NUM_P16);

    always_comb begin
        diff  = {1'b0, s_paid} - {1'b0, s_change};
        sum33 = {rev_reg[REV_W-1], rev_reg} + {{(REV_W-16){diff[16]}}, diff};
        if (sum33[REV_W] != sum33[REV_W-1]) begin
            rev_sat = sum33[REV_W] ? REV_MIN : REV_MAX;
        end else begin
            rev_sat = sum33[REV_W-1:0];
        end
        bin_inc = (bin_rd == COUNT_MAX) ? bin_rd : bin_rd + 1'b1;
    end

    assign mem_rd_en   = s_accept && (s_tuser[0] == ACT_SALE) && in_range;
    assign mem_wr_en   = (state_reg == S_CLEAR) || (state_reg == S_UPD);
    assign mem_wr_addr = (state_reg == S_CLEAR) ? clr_addr_reg : pid_reg[IDX_W-1:0];
    assign mem_wr_data = (state_reg == S_CLEAR) ? '0 : bin_inc;
    assign div_start   = s_accept && (s_tuser[0] == ACT_REPORT);

    shm_bin_mem #(
        .DEPTH  (NUM_PRODUCTS),
        .ADDR_W (IDX_W)
    ) u_bins (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (s_pid[IDX_W-1:0]),
        .rd_data (bin_rd),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    shm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rev_reg),
        .divisor  (sales_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pid_next      = pid_reg;
        sales_next    = sales_reg;
        rev_next      = rev_reg;
        mode_id_next  = mode_id_reg;
        mode_cnt_next = mode_cnt_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        case (state_reg)
            S_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == ACT_REPORT) begin
                        state_next = S_DIV;
                    end else begin
                        pid_next   = s_pid;
                        sales_next = (sales_reg == COUNT_MAX) ? sales_reg
                                                              : sales_reg + 1'b1;
                        rev_next   = rev_sat;
                        if (in_range) begin
                            state_next = S_UPD;
                        end
                    end
                end
            end
            S_UPD: begin
                if (bin_inc > mode_cnt_reg) begin
                    mode_cnt_next = bin_inc;
                    mode_id_next  = pid_reg[MODE_W-1:0];
                end
                state_next = S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_next.total_sales   = sales_reg;
                    out_next.revenue_cents = rev_reg;
                    out_next.mean_cents    = (sales_reg == '0) ? '0 : div_q;
                    out_next.top_product   = mode_id_reg;
                    out_next.top_count     = mode_cnt_reg;
                    m_valid_next  = 1'b1;
                    sales_next    = '0;
                    rev_next      = '0;
                    mode_id_next  = NO_MODE;
                    mode_cnt_next = '0;
                    clr_addr_next = '0;
                    state_next    = S_CLEAR;
                end
            end
            default: begin
                state_next    = S_CLEAR;
                clr_addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            sales_reg    <= '0;
            rev_reg      <= '0;
            mode_id_reg  <= NO_MODE;
            mode_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            sales_reg    <= sales_next;
            rev_reg      <= rev_next;
            mode_id_reg  <= mode_id_next;
            mode_cnt_reg <= mode_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        pid_reg <= pid_next;
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

endmodule

@@ sv/shm_checker.sv @@
// Port-level checks for sales_histogram_mode_mean, bound to the top level.
// Depends on shm_pkg for the bus widths and constants.
module shm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [shm_pkg::S_USER_W-1:0]  s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [shm_pkg::M_DATA_W-1:0]  m_tdata
);
    import shm_pkg::*;

    // a stalled report holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("report dropped or changed while stalled");

    // no mode exactly when the mode count is zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[87:80] == NO_MODE) == (m_tdata[103:88] == '0)))
        else $error("mode id and mode count disagree");

    // the mode's bin never holds more than the sales total
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[103:88] <= m_tdata[15:0]))
        else $error("mode count above total sales");

    // an empty report has no revenue and zero mean
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[15:0] == '0) |-> (m_tdata[79:16] == '0))
        else $error("empty report carries revenue or mean");

    // a report request closes the input while the mean is worked out
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == ACT_REPORT) |=> !s_tready)
        else $error("input open during report");

endmodule

bind sales_histogram_mode_mean shm_checker u_shm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
